// ===== design/cma_pkg.sv =====
package cma_pkg;

  // Field and datapath widths
  localparam int SAMPLE_BITS = 24;
  localparam int LEN_BITS    = 7;
  localparam int SUM_BITS    = SAMPLE_BITS + LEN_BITS;
  localparam int STEP_BITS   = $clog2(SUM_BITS + 1);

  // Window length register
  localparam logic [LEN_BITS-1:0] WIN_RESET = 7'd5;
  localparam logic [LEN_BITS-1:0] WIN_MIN   = 7'd2;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          last;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] average;
    logic                          last_res;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SETUP,
    ST_SUM,
    ST_ABS,
    ST_DIV,
    ST_FIN,
    ST_OUT
  } state_t;

endpackage

// ===== design/cma_ram.sv =====
module cma_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/centered_moving_average.sv =====
// After the input that closes a window: CHECK sizes it to count samples (at most the window
//   length), SETUP sets the read address, SUM reads and adds them, ABS takes the magnitude,
//   DIV divides, FIN restores the sign and OUT offers the result. Results are formed one at a
//   time, paced by the history memory read (one sample a cycle) and the one-bit-a-cycle divider.
// An item that closes no window returns to idle after CHECK; input is held while results drain.
// Synchronous reset: window length 5, empty sequence, history left unwritten.
module centered_moving_average #(
  parameter int MAX_LENGTH = 64
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  src_valid,
  output logic                                  src_stall,
  input  cma_pkg::in_item_t                     src_data,
  output logic                                  res_valid,
  input  logic                                  res_stall,
  output cma_pkg::out_item_t                    res_data,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [cma_pkg::LEN_BITS-1:0]          cfg_data
);

  localparam int PTR_BITS  = $clog2(MAX_LENGTH);
  localparam int SEEN_BITS = $clog2(MAX_LENGTH + 1);
  localparam int AW        = PTR_BITS + 1;
  localparam int CW        = (AW > cma_pkg::LEN_BITS) ? AW : cma_pkg::LEN_BITS;
  localparam int LB        = cma_pkg::LEN_BITS;
  localparam int SB        = cma_pkg::SAMPLE_BITS;
  localparam int UB        = cma_pkg::SUM_BITS;
  localparam int TB        = cma_pkg::STEP_BITS;
  localparam logic [LB-1:0] LEN_CAP = LB'((MAX_LENGTH < 64) ? MAX_LENGTH : 64);

  cma_pkg::state_t state, state_next;

  logic [LB-1:0]        win_len;
  logic [PTR_BITS-1:0]  wp;
  logic [SEEN_BITS-1:0] seen;
  logic [SEEN_BITS-1:0] noi;
  logic                 seq_last;
  logic [LB-1:0]        cnt;
  logic [PTR_BITS-1:0]  lo;
  logic [PTR_BITS-1:0]  raddr;
  logic [LB-1:0]        issue_left;
  logic [LB-1:0]        acc_left;
  logic                 rd_pend;
  logic [UB-1:0]        sum;
  logic                 neg;
  logic [UB-1:0]        quot_sh;
  logic [LB-1:0]        rem;
  logic [TB-1:0]        step;
  logic [SB-1:0]        rd_data;

  logic                 src_xfer;
  logic                 res_xfer;
  logic [SEEN_BITS-1:0] seen_next;

  logic [LB-1:0] back;
  logic [LB-1:0] front;
  logic [CW-1:0] age;
  logic [CW-1:0] fm1;
  logic [CW-1:0] later;
  logic [CW-1:0] avail;
  logic [CW-1:0] earlier;
  logic          emit;
  logic [AW-1:0] base;
  logic [AW-1:0] start_addr;

  logic [LB:0]   trial;
  logic          take;
  logic [LB:0]   trial_rem;
  logic [UB-1:0] quot_mag;

  assign src_xfer  = src_valid && !src_stall;
  assign res_xfer  = res_valid && !res_stall;
  assign cfg_ready = 1'b1;

  // History ring
  cma_ram #(
    .WIDTH(SB),
    .DEPTH(MAX_LENGTH)
  ) u_hist (
    .clk  (clk),
    .we   (src_xfer),
    .waddr(wp),
    .wdata(src_data.sample),
    .raddr(raddr),
    .rdata(rd_data)
  );

  // Window bounds for the oldest pending position
  always_comb begin
    back    = win_len >> 1;
    front   = win_len - back;
    age     = CW'(noi) - CW'(1);
    fm1     = CW'(front) - CW'(1);
    emit    = (noi != '0) && (seq_last || (age >= fm1));
    later   = (age < fm1) ? age : fm1;
    avail   = CW'(seen) - CW'(1) - age;
    earlier = (avail < CW'(back)) ? avail : CW'(back);
  end

  // Ring address of the newest sample in the window
  always_comb begin
    base       = AW'(wp) + AW'(MAX_LENGTH - 1) - AW'(lo);
    start_addr = (base >= AW'(MAX_LENGTH)) ? base - AW'(MAX_LENGTH) : base;
  end

  // One restoring division step
  always_comb begin
    trial     = {rem, quot_sh[UB-1]};
    take      = trial >= {1'b0, cnt};
    trial_rem = take ? trial - {1'b0, cnt} : trial;
    quot_mag  = sum[UB-1] ? (~sum + UB'(1)) : sum;
  end

  assign seen_next = (seen == SEEN_BITS'(MAX_LENGTH)) ? seen : seen + SEEN_BITS'(1);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      cma_pkg::ST_IDLE:  if (src_xfer) state_next = cma_pkg::ST_CHECK;
      cma_pkg::ST_CHECK: state_next = emit ? cma_pkg::ST_SETUP : cma_pkg::ST_IDLE;
      cma_pkg::ST_SETUP: state_next = cma_pkg::ST_SUM;
      cma_pkg::ST_SUM:   if (rd_pend && acc_left == LB'(1)) state_next = cma_pkg::ST_ABS;
      cma_pkg::ST_ABS:   state_next = cma_pkg::ST_DIV;
      cma_pkg::ST_DIV:   if (step == TB'(UB - 1)) state_next = cma_pkg::ST_FIN;
      cma_pkg::ST_FIN:   state_next = cma_pkg::ST_OUT;
      cma_pkg::ST_OUT:   if (res_xfer) state_next = cma_pkg::ST_CHECK;
      default:           state_next = cma_pkg::ST_IDLE;
    endcase
  end

  // Handshake outputs
  always_comb begin
    src_stall = 1'b1;
    res_valid = 1'b0;
    case (state)
      cma_pkg::ST_IDLE: src_stall = 1'b0;
      cma_pkg::ST_OUT:  res_valid = 1'b1;
      default: begin
        src_stall = 1'b1;
        res_valid = 1'b0;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= cma_pkg::ST_IDLE;
      win_len  <= cma_pkg::WIN_RESET;
      wp       <= '0;
      seen     <= '0;
      noi      <= '0;
      seq_last <= 1'b0;
      rd_pend  <= 1'b0;
    end else begin
      state <= state_next;

      // Take a length write, ignore lengths below two, cap long ones
      if (cfg_valid && cfg_ready && cfg_data >= cma_pkg::WIN_MIN) begin
        win_len <= (cfg_data > LEN_CAP) ? LEN_CAP : cfg_data;
      end

      case (state)
        cma_pkg::ST_IDLE: begin
          if (src_xfer) begin
            wp       <= (wp == PTR_BITS'(MAX_LENGTH - 1)) ? '0 : wp + PTR_BITS'(1);
            seen     <= seen_next;
            seq_last <= src_data.last;
            if (noi < seen_next) begin
              noi <= noi + SEEN_BITS'(1);
            end
          end
        end
        cma_pkg::ST_CHECK: begin
          // End of sequence once every pending result has gone
          if (!emit && seq_last) begin
            seen     <= '0;
            noi      <= '0;
            seq_last <= 1'b0;
          end
        end
        cma_pkg::ST_SETUP: rd_pend <= 1'b0;
        cma_pkg::ST_SUM:   rd_pend <= (issue_left != '0);
        cma_pkg::ST_FIN:   noi <= noi - SEEN_BITS'(1);
        default:           rd_pend <= 1'b0;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      cma_pkg::ST_CHECK: begin
        cnt <= LB'(earlier + later + CW'(1));
        lo  <= PTR_BITS'(age - later);
      end
      cma_pkg::ST_SETUP: begin
        raddr      <= PTR_BITS'(start_addr);
        issue_left <= cnt;
        acc_left   <= cnt;
        sum        <= '0;
      end
      cma_pkg::ST_SUM: begin
        // Step back through the ring towards older samples
        if (issue_left != '0) begin
          raddr      <= (raddr == '0) ? PTR_BITS'(MAX_LENGTH - 1) : raddr - PTR_BITS'(1);
          issue_left <= issue_left - LB'(1);
        end
        if (rd_pend) begin
          sum      <= sum + {{LB{rd_data[SB-1]}}, rd_data};
          acc_left <= acc_left - LB'(1);
        end
      end
      cma_pkg::ST_ABS: begin
        neg     <= sum[UB-1];
        quot_sh <= quot_mag;
        rem     <= '0;
        step    <= '0;
      end
      cma_pkg::ST_DIV: begin
        rem     <= LB'(trial_rem);
        quot_sh <= {quot_sh[UB-2:0], take};
        step    <= step + TB'(1);
      end
      cma_pkg::ST_FIN: begin
        // Restore the sign; the quotient always fits the sample range
        res_data.average  <= SB'(neg ? (~quot_sh + UB'(1)) : quot_sh);
        res_data.last_res <= seq_last && (noi == SEEN_BITS'(1));
      end
      default: begin
        // Hold
      end
    endcase
  end

endmodule
